>>> hw/rtl/srfa_pkg.sv
package srfa_pkg;

   localparam int DistWidth    = 13;
   localparam int AngleWidth   = 8;
   localparam int WeightWidth  = 9;
   localparam int DecimWidth   = 4;
   localparam int StepWidth    = 7;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 13;
   localparam int DistFracBits = 4;

   // opcodes
   localparam logic [1:0] OpScan  = 2'd0;
   localparam logic [1:0] OpStart = 2'd1;
   localparam logic [1:0] OpStop  = 2'd2;

   // alarm levels
   localparam logic [1:0] AlarmSafe    = 2'd0;
   localparam logic [1:0] AlarmWarning = 2'd1;
   localparam logic [1:0] AlarmDanger  = 2'd2;

   // system modes
   localparam logic [1:0] ModeScanning = 2'd0;
   localparam logic [1:0] ModeStopped  = 2'd1;
   localparam logic [1:0] ModeAlarm    = 2'd2;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] CsrWarning  = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CsrDanger   = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CsrMaxRange = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CsrJump     = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CsrBlend    = 3'd4;
   localparam logic [CsrAddrWidth-1:0] CsrDecim    = 3'd5;
   localparam logic [CsrAddrWidth-1:0] CsrStep     = 3'd6;
   localparam logic [CsrAddrWidth-1:0] CsrEnd      = 3'd7;

   // reset values
   localparam logic [DistWidth-1:0]   WarningReset  = DistWidth'(30 << DistFracBits);
   localparam logic [DistWidth-1:0]   DangerReset   = DistWidth'(10 << DistFracBits);
   localparam logic [DistWidth-1:0]   MaxRangeReset = DistWidth'(400 << DistFracBits);
   localparam logic [DistWidth-1:0]   JumpReset     = DistWidth'(50 << DistFracBits);
   localparam logic [WeightWidth-1:0] BlendReset    = 9'd77;
   localparam logic [WeightWidth-1:0] BlendFull     = 9'd256;
   localparam logic [DecimWidth-1:0]  DecimReset    = 4'd10;
   localparam logic [StepWidth-1:0]   StepReset     = 7'd5;
   localparam logic [AngleWidth-1:0]  EndReset      = 8'd180;
   localparam logic [AngleWidth-1:0]  AngleCenter   = 8'd90;

   typedef struct packed {
      logic [DistWidth-1:0]   warning_distance;
      logic [DistWidth-1:0]   danger_distance;
      logic [DistWidth-1:0]   max_range;
      logic [DistWidth-1:0]   jump_limit;
      logic [WeightWidth-1:0] blend_weight;
      logic [DecimWidth-1:0]  decimation;
      logic [StepWidth-1:0]   sweep_step;
      logic [AngleWidth-1:0]  sweep_end;
   } cfg_type;

   function automatic logic [1:0] classify(input logic [DistWidth-1:0] d,
                                           input cfg_type cfg);
      logic [1:0] lvl;
      if (d == '0 || d > cfg.max_range) begin
         lvl = AlarmSafe;
      end else if (d <= cfg.danger_distance) begin
         lvl = AlarmDanger;
      end else if (d <= cfg.warning_distance) begin
         lvl = AlarmWarning;
      end else begin
         lvl = AlarmSafe;
      end
      return lvl;
   endfunction

endpackage

>>> hw/rtl/srfa_csr.sv
module srfa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [srfa_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [srfa_pkg::CsrDataWidth-1:0]   csr_wdata,
   output srfa_pkg::cfg_type                   cfg
);
   import srfa_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warning_distance <= WarningReset;
         cfg_ff.danger_distance  <= DangerReset;
         cfg_ff.max_range        <= MaxRangeReset;
         cfg_ff.jump_limit       <= JumpReset;
         cfg_ff.blend_weight     <= BlendReset;
         cfg_ff.decimation       <= DecimReset;
         cfg_ff.sweep_step       <= StepReset;
         cfg_ff.sweep_end        <= EndReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            CsrWarning:  cfg_ff.warning_distance <= csr_wdata;
            CsrDanger:   cfg_ff.danger_distance  <= csr_wdata;
            CsrMaxRange: cfg_ff.max_range        <= csr_wdata;
            CsrJump:     cfg_ff.jump_limit       <= csr_wdata;
            CsrBlend:    cfg_ff.blend_weight     <= csr_wdata[WeightWidth-1:0];
            CsrDecim:    cfg_ff.decimation       <= csr_wdata[DecimWidth-1:0];
            CsrStep:     cfg_ff.sweep_step       <= csr_wdata[StepWidth-1:0];
            CsrEnd:      cfg_ff.sweep_end        <= csr_wdata[AngleWidth-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/srfa_filter.sv
module srfa_filter (
   input  logic [srfa_pkg::DistWidth-1:0] old_range,
   input  logic [srfa_pkg::DistWidth-1:0] raw_distance,
   input  srfa_pkg::cfg_type              cfg,
   output logic [srfa_pkg::DistWidth-1:0] new_range
);
   import srfa_pkg::*;

   logic                   reject;
   logic [DistWidth:0]     old_ext;
   logic [DistWidth:0]     raw_ext;
   logic [DistWidth-1:0]   pick;
   logic [WeightWidth-1:0] weight;
   logic signed [DistWidth:0]          diff;
   logic signed [WeightWidth:0]        weight_s;
   logic signed [DistWidth+10:0]       prod;
   logic signed [DistWidth+10:0]       sum;

   always_comb begin
      old_ext = {1'b0, old_range};
      raw_ext = {1'b0, raw_distance};
      reject  = (raw_distance == '0) || (raw_distance >= cfg.max_range) ||
                ((old_range != '0) &&
                 ((raw_ext > old_ext + {1'b0, cfg.jump_limit}) ||
                  (raw_ext + {1'b0, cfg.jump_limit} < old_ext)));
      pick    = reject ? old_range : raw_distance;
      weight  = (cfg.blend_weight > BlendFull) ? BlendFull : cfg.blend_weight;

      // old*(256-w) + pick*w == old*256 + (pick-old)*w
      diff     = $signed({1'b0, pick}) - $signed({1'b0, old_range});
      weight_s = $signed({1'b0, weight});
      prod     = diff * weight_s;
      sum      = $signed({3'b000, old_range, 8'h00}) + prod + 24'sd128;

      if (old_range == '0) begin
         new_range = pick;
      end else begin
         new_range = sum[DistWidth+7:8];
      end
   end

endmodule

>>> hw/rtl/sweep_range_filter_alarm_top.sv
// a request is held in the request register, then in the response register
// one request per cycle if not stalled, every request yields exactly one response
// while a response waits, one more request is held in the request register,
// then req_tready stays low until the response transfers
// reset (synchronous, active high) restores the configuration defaults, the
// sweep to 90 degrees rising, scanning enabled and a zero filtered range
module sweep_range_filter_alarm_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // raw_distance[12:0], zero fill
   input  logic [2:0]  req_tuser,   // opcode[1:0], sample_ok[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // servo_angle[7:0], report_angle[15:8],
                                    // filtered_distance[28:16], alarm_level[30:29],
                                    // system_mode[32:31], zero fill
   output logic [1:0]  rsp_tuser,   // servo_move[0], report_valid[1]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [12:0] csr_wdata
);
   import srfa_pkg::*;

   cfg_type cfg;

   logic                   s1_valid_ff;
   logic [1:0]             s1_op_ff;
   logic [DistWidth-1:0]   s1_raw_ff;
   logic                   s1_ok_ff;
   logic                   advance;

   logic                   scan_en_ff, scan_en_in;
   logic [AngleWidth-1:0]  angle_ff, angle_in;
   logic                   rising_ff, rising_in;
   logic [DecimWidth-1:0]  count_ff, count_in;
   logic [DistWidth-1:0]   range_ff, range_in;
   logic [1:0]             alarm_ff, alarm_in;
   logic [1:0]             mode_ff, mode_in;

   logic                   move_in, rep_in;
   logic [AngleWidth-1:0]  target_in, rep_angle_in;

   logic                   rsp_valid_ff;
   logic                   move_ff, rep_ff;
   logic [AngleWidth-1:0]  target_ff, rep_angle_ff;
   logic [DistWidth-1:0]   out_range_ff;
   logic [1:0]             out_alarm_ff, out_mode_ff;

   logic [DistWidth-1:0]   blended;
   logic [DecimWidth-1:0]  need;
   logic [DecimWidth:0]    count_inc;
   logic [AngleWidth:0]    angle_up;

   srfa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srfa_filter u_filter (
      .old_range    (range_ff),
      .raw_distance (s1_raw_ff),
      .cfg          (cfg),
      .new_range    (blended)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         s1_op_ff  <= req_tuser[1:0];
         s1_ok_ff  <= req_tuser[2];
         s1_raw_ff <= req_tdata[DistWidth-1:0];
      end
   end

   always_comb begin
      scan_en_in   = scan_en_ff;
      angle_in     = angle_ff;
      rising_in    = rising_ff;
      count_in     = count_ff;
      range_in     = range_ff;
      alarm_in     = alarm_ff;
      mode_in      = mode_ff;
      move_in      = 1'b0;
      target_in    = '0;
      rep_in       = 1'b0;
      rep_angle_in = '0;
      need         = (cfg.decimation == '0) ? DecimWidth'(1) : cfg.decimation;
      count_inc    = {1'b0, count_ff} + (DecimWidth+1)'(1);
      angle_up     = {1'b0, angle_ff} + {2'b00, cfg.sweep_step};

      priority if (s1_op_ff == OpStart) begin
         scan_en_in = 1'b1;
         mode_in    = ModeScanning;
      end else if (s1_op_ff == OpStop) begin
         scan_en_in = 1'b0;
         mode_in    = ModeStopped;
         move_in    = 1'b1;
         target_in  = AngleCenter;
      end else if (s1_op_ff == OpScan && scan_en_ff) begin
         move_in   = 1'b1;
         target_in = angle_ff;
         if (count_inc >= {1'b0, need}) begin
            if (s1_ok_ff) begin
               range_in = blended;
            end
            count_in     = '0;
            alarm_in     = classify(range_in, cfg);
            mode_in      = (alarm_in == AlarmDanger) ? ModeAlarm : ModeScanning;
            rep_in       = 1'b1;
            rep_angle_in = angle_ff;
         end else begin
            count_in = count_inc[DecimWidth-1:0];
         end
         if (rising_ff) begin
            if (angle_up >= {1'b0, cfg.sweep_end}) begin
               angle_in  = cfg.sweep_end;
               rising_in = 1'b0;
            end else begin
               angle_in = angle_up[AngleWidth-1:0];
            end
         end else begin
            if (angle_ff <= {1'b0, cfg.sweep_step}) begin
               angle_in  = '0;
               rising_in = 1'b1;
            end else begin
               angle_in = angle_ff - {1'b0, cfg.sweep_step};
            end
         end
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_en_ff <= 1'b1;
         angle_ff   <= AngleCenter;
         rising_ff  <= 1'b1;
         count_ff   <= '0;
         range_ff   <= '0;
         alarm_ff   <= AlarmSafe;
         mode_ff    <= ModeScanning;
      end else if (advance) begin
         scan_en_ff <= scan_en_in;
         angle_ff   <= angle_in;
         rising_ff  <= rising_in;
         count_ff   <= count_in;
         range_ff   <= range_in;
         alarm_ff   <= alarm_in;
         mode_ff    <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         move_ff      <= move_in;
         target_ff    <= target_in;
         rep_ff       <= rep_in;
         rep_angle_ff <= rep_angle_in;
         out_range_ff <= range_in;
         out_alarm_ff <= alarm_in;
         out_mode_ff  <= mode_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rep_ff, move_ff};
   assign rsp_tdata  = {7'b0, out_mode_ff, out_alarm_ff, out_range_ff,
                        rep_angle_ff, target_ff};

   a_idle_angle_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == 8'd0)
      else $error("servo angle nonzero without a move");

   a_report_needs_move : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tdata[15:8] == rsp_tdata[7:0])
      else $error("report without matching servo move");

   a_stopped_holds_sweep : assert property (@(posedge clock) disable iff (reset)
      !scan_en_ff |=> $stable(count_ff) && $stable(angle_ff) && $stable(range_ff))
      else $error("sweep state changed while stopped");

endmodule
